### hdl/led_blink_controller_defines.svh
// Assertion macros used by the LED blink controller checker.
`ifndef LED_BLINK_CONTROLLER_DEFINES_SVH
`define LED_BLINK_CONTROLLER_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define LBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define LBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define LBC_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lbc_pkg.sv
// Types and constants of the LED blink controller.
`default_nettype none

package lbc_pkg;

    localparam int NUM_LEDS    = 3;
    localparam int TIME_BITS   = 16;
    localparam int OUT_LEDS    = 3;
    localparam int SHOWN_LEDS  = (NUM_LEDS < OUT_LEDS) ? NUM_LEDS : OUT_LEDS;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [1:0] {
        FN_TICK     = 2'd0,
        FN_ACTION   = 2'd1,
        FN_BLINK    = 2'd2,
        FN_SHUTDOWN = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ACT_ON     = 2'd0,
        ACT_OFF    = 2'd1,
        ACT_TOGGLE = 2'd2,
        ACT_KEEP   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        UOP_NONE,
        UOP_TICK,
        UOP_ACTION,
        UOP_BLINK,
        UOP_SHUTDOWN
    } t_unit_op;

    // Registered request.
    typedef struct packed {
        t_func       func;
        logic [1:0]  led_index;
        t_action     action;
        t_time       on_t;
        t_time       off_t;
        logic        rep;
        logic        kill;
    } t_req;

    // Command to one LED unit.
    typedef struct packed {
        t_unit_op    op;
        t_action     action;
        t_time       on_t;
        t_time       off_t;
        logic        rep;
        logic        kill;
    } t_led_cmd;

    // Level and drive of one LED after the command.
    typedef struct packed {
        logic level;
        logic drive;
    } t_led_stat;

endpackage

`default_nettype wire

### hdl/lbc_if.sv
// Request and response channel interfaces of the LED blink controller.
`default_nettype none

interface lbc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [1:0]  led_index;
    logic [1:0]  action_kind;
    logic [15:0] on_ticks;
    logic [15:0] off_ticks;
    logic        repeat_blink;
    logic        lights_off;

    modport source (
        output valid, func, led_index, action_kind, on_ticks, off_ticks,
               repeat_blink, lights_off,
        input  ready
    );
    modport sink (
        input  valid, func, led_index, action_kind, on_ticks, off_ticks,
               repeat_blink, lights_off,
        output ready
    );
endinterface

interface lbc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  led_levels;
    logic [2:0]  drive_enables;
    logic        accepted;

    modport source (
        output valid, led_levels, drive_enables, accepted,
        input  ready
    );
    modport sink (
        input  valid, led_levels, drive_enables, accepted,
        output ready
    );
endinterface

`default_nettype wire

### hdl/lbc_led_unit.sv
// State and phase logic of one LED: level, drive, blink counter.
`default_nettype none

module lbc_led_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lbc_pkg::t_led_cmd i_cmd,
    output lbc_pkg::t_led_stat     o_next
);
    import lbc_pkg::*;

    localparam t_time TIME_ONE = t_time'(1);

    logic  r_level, r_drive, r_run, r_off, r_rep;
    t_time r_ticks, r_on_dur, r_off_dur;
    logic  n_level, n_drive, n_run, n_off, n_rep;
    t_time n_ticks, n_on_dur, n_off_dur;

    always_comb begin
        n_level   = r_level;
        n_drive   = r_drive;
        n_run     = r_run;
        n_off     = r_off;
        n_rep     = r_rep;
        n_ticks   = r_ticks;
        n_on_dur  = r_on_dur;
        n_off_dur = r_off_dur;
        unique case (i_cmd.op)
            UOP_NONE: begin
            end
            UOP_TICK: begin
                if (r_run) begin
                    if (r_ticks > TIME_ONE) begin
                        n_ticks = r_ticks - TIME_ONE;
                    end else if (!r_off) begin
                        // on phase expired: go dark, then off phase or stop
                        n_level = 1'b0;
                        if (r_rep) begin
                            n_off   = 1'b1;
                            n_ticks = r_off_dur;
                        end else begin
                            n_run   = 1'b0;
                            n_ticks = '0;
                        end
                    end else begin
                        n_level = 1'b1;
                        n_off   = 1'b0;
                        n_ticks = r_on_dur;
                    end
                end
            end
            UOP_ACTION: begin
                unique case (i_cmd.action)
                    ACT_ON:     n_level = 1'b1;
                    ACT_OFF:    n_level = 1'b0;
                    ACT_TOGGLE: n_level = ~r_level;
                    ACT_KEEP:   n_level = r_level;
                endcase
                n_run   = 1'b0;
                n_off   = 1'b0;
                n_ticks = '0;
            end
            UOP_BLINK: begin
                n_level   = 1'b1;
                n_run     = 1'b1;
                n_off     = 1'b0;
                n_on_dur  = i_cmd.on_t;
                n_off_dur = i_cmd.off_t;
                n_rep     = i_cmd.rep;
                n_ticks   = i_cmd.on_t;
            end
            UOP_SHUTDOWN: begin
                n_run   = 1'b0;
                n_off   = 1'b0;
                n_ticks = '0;
                if (i_cmd.kill) begin
                    n_level = 1'b0;
                    n_drive = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= 1'b0;
            r_drive   <= 1'b1;
            r_run     <= 1'b0;
            r_off     <= 1'b0;
            r_rep     <= 1'b0;
            r_ticks   <= '0;
            r_on_dur  <= '0;
            r_off_dur <= '0;
        end else begin
            r_level   <= n_level;
            r_drive   <= n_drive;
            r_run     <= n_run;
            r_off     <= n_off;
            r_rep     <= n_rep;
            r_ticks   <= n_ticks;
            r_on_dur  <= n_on_dur;
            r_off_dur <= n_off_dur;
        end
    end

    assign o_next.level = n_level;
    assign o_next.drive = n_drive;

endmodule

`default_nettype wire

### hdl/led_blink_controller.sv
// Top level of the LED blink controller: request register, LED units, result register.
//
//   channel   dir   handshake      payload
//   i_req     in    valid/ready    func, led_index, action_kind, on/off_ticks, flags
//   o_rsp     out   valid/ready    led_levels, drive_enables, accepted
//
// One request per cycle unless the result stalls. A taken request goes to the request
// register, which feeds the LED units, whose state and the result register
// update in the same cycle. A stalled result stops that stage; the request
// register still takes a request while empty. Synchronous reset clears both
// stages, turns all LEDs off, enables all drives and stops all blinks.
`default_nettype none

module led_blink_controller (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lbc_in_if.sink     i_req,
    lbc_out_if.source  o_rsp
);
    import lbc_pkg::*;

    logic       r_in_valid;
    t_req       r_req;
    logic       r_out_valid;
    logic [2:0] r_levels;
    logic [2:0] r_drives;
    logic       r_accepted;

    logic       w_advance;
    logic       w_step;
    logic       w_idx_ok;
    logic [2:0] n_levels;
    logic [2:0] n_drives;
    logic       n_accepted;

    t_led_cmd   w_cmd  [NUM_LEDS];
    t_led_stat  w_next [NUM_LEDS];

    assign w_advance   = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || w_advance;
    assign w_step      = r_in_valid && w_advance;
    assign w_idx_ok    = 32'(r_req.led_index) < NUM_LEDS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.func      <= t_func'(i_req.func);
            r_req.led_index <= i_req.led_index;
            r_req.action    <= t_action'(i_req.action_kind);
            r_req.on_t      <= t_time'(i_req.on_ticks);
            r_req.off_t     <= t_time'(i_req.off_ticks);
            r_req.rep       <= i_req.repeat_blink;
            r_req.kill      <= i_req.lights_off;
        end
    end

    // Decode the request into one command per LED.
    always_comb begin
        for (int i = 0; i < NUM_LEDS; i++) begin
            w_cmd[i].action = r_req.action;
            w_cmd[i].on_t   = r_req.on_t;
            w_cmd[i].off_t  = r_req.off_t;
            w_cmd[i].rep    = r_req.rep;
            w_cmd[i].kill   = r_req.kill;
            w_cmd[i].op     = UOP_NONE;
            if (w_step) begin
                unique case (r_req.func)
                    FN_TICK:     w_cmd[i].op = UOP_TICK;
                    FN_SHUTDOWN: w_cmd[i].op = UOP_SHUTDOWN;
                    FN_ACTION: begin
                        if (w_idx_ok && 32'(r_req.led_index) == i) begin
                            w_cmd[i].op = UOP_ACTION;
                        end
                    end
                    FN_BLINK: begin
                        if (w_idx_ok && 32'(r_req.led_index) == i) begin
                            w_cmd[i].op = UOP_BLINK;
                        end
                    end
                endcase
            end
        end
    end

    for (genvar g = 0; g < NUM_LEDS; g++) begin : g_led
        lbc_led_unit u_led (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[g]),
            .o_next  (w_next[g])
        );
    end

    always_comb begin
        n_levels = '0;
        n_drives = '0;
        for (int i = 0; i < SHOWN_LEDS; i++) begin
            n_levels[i] = w_next[i].level;
            n_drives[i] = w_next[i].drive;
        end
        // reject action and blink requests aimed past the last LED
        n_accepted = w_idx_ok || r_req.func == FN_TICK || r_req.func == FN_SHUTDOWN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_levels   <= n_levels;
            r_drives   <= n_drives;
            r_accepted <= n_accepted;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.led_levels    = r_levels;
    assign o_rsp.drive_enables = r_drives;
    assign o_rsp.accepted      = r_accepted;

endmodule

`default_nettype wire

### hdl/lbc_checker.sv
// Port-level checks of the LED blink controller and their binding to the top level.
`default_nettype none
`include "led_blink_controller_defines.svh"

module lbc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_drives
);
    logic       w_out_fire;
    logic       w_drive_rose;
    logic [2:0] r_seen_drives;

    assign w_out_fire   = i_out_valid && i_out_ready;
    assign w_drive_rose = |(i_drives & ~r_seen_drives);

    // Track drives of the last delivered result; only reset may raise them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_drives <= 3'b111;
        end else if (w_out_fire) begin
            r_seen_drives <= i_drives;
        end
    end

    `LBC_ASSERT_NEXT(a_valid_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    `LBC_ASSERT_RST(a_reset_empty, !i_rst_n, !i_out_valid, "result valid after reset")
    `LBC_ASSERT_NOW(a_drive_monotone, w_out_fire, !w_drive_rose, "drive enable came back")
    `LBC_ASSERT_NOW(a_ready_flow, i_out_ready, i_in_ready, "request stalled needlessly")

endmodule

bind led_blink_controller lbc_checker u_lbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_drives    (o_rsp.drive_enables)
);

`default_nettype wire

### tb/sv/led_blink_controller_test.sv
// Self-checking testbench for the LED blink controller: random requests against a predictor.
`timescale 1ns / 100ps

module led_blink_controller_test;
    import lbc_pkg::*;

    localparam int RANDOM_REQS  = 1400;
    localparam int CALM_TAIL    = 100;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE       = 8;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic [2:0] levels;
        logic [2:0] drives;
        logic       ok;
    } t_status;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lbc_in_if  req_bus ();
    lbc_out_if rsp_bus ();

    led_blink_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    // Predicted LED state
    logic  lamp       [NUM_LEDS];
    logic  drive      [NUM_LEDS];
    logic  running    [NUM_LEDS];
    logic  off_phase  [NUM_LEDS];
    t_time remain     [NUM_LEDS];
    t_time on_len     [NUM_LEDS];
    t_time off_len    [NUM_LEDS];
    logic  repeating  [NUM_LEDS];

    t_req    pending_reqs [$];
    t_status expected_status [$];

    int mismatches = 0;
    int cycle_count = 0;
    int idle_pct = 0;
    int req_gap = 0;
    int rsp_gap = 0;
    int results_seen = 0;
    int n_tick = 0, n_action = 0, n_blink = 0, n_shutdown = 0, n_rejected = 0;

    function automatic void clear_leds();
        for (int i = 0; i < NUM_LEDS; i++) begin
            lamp[i] = 1'b0;
            drive[i] = 1'b1;
            running[i] = 1'b0;
            off_phase[i] = 1'b0;
            remain[i] = '0;
            on_len[i] = '0;
            off_len[i] = '0;
            repeating[i] = 1'b0;
        end
    endfunction

    function automatic t_status apply_request(t_req r);
        t_status s;
        int      n;
        s = '0;
        s.ok = 1'b1;
        case (r.func)
            FN_TICK: begin
                for (int i = 0; i < NUM_LEDS; i++) begin
                    if (running[i]) begin
                        if (remain[i] > 1) begin
                            remain[i] = remain[i] - 1'b1;
                        end else if (!off_phase[i]) begin
                            lamp[i] = 1'b0;
                            if (repeating[i]) begin
                                off_phase[i] = 1'b1;
                                remain[i] = off_len[i];
                            end else begin
                                running[i] = 1'b0;
                                remain[i] = '0;
                            end
                        end else begin
                            lamp[i] = 1'b1;
                            off_phase[i] = 1'b0;
                            remain[i] = on_len[i];
                        end
                    end
                end
            end
            FN_SHUTDOWN: begin
                for (int i = 0; i < NUM_LEDS; i++) begin
                    running[i] = 1'b0;
                    off_phase[i] = 1'b0;
                    remain[i] = '0;
                    if (r.kill) begin
                        lamp[i] = 1'b0;
                        drive[i] = 1'b0;
                    end
                end
            end
            default: begin
                if (r.led_index >= NUM_LEDS) begin
                    s.ok = 1'b0;
                end else begin
                    n = r.led_index;
                    if (r.func == FN_ACTION) begin
                        case (r.action)
                            ACT_ON:     lamp[n] = 1'b1;
                            ACT_OFF:    lamp[n] = 1'b0;
                            ACT_TOGGLE: lamp[n] = ~lamp[n];
                            default:    ;
                        endcase
                        running[n] = 1'b0;
                        off_phase[n] = 1'b0;
                        remain[n] = '0;
                    end else begin
                        lamp[n] = 1'b1;
                        running[n] = 1'b1;
                        off_phase[n] = 1'b0;
                        on_len[n] = r.on_t;
                        off_len[n] = r.off_t;
                        repeating[n] = r.rep;
                        remain[n] = r.on_t;
                    end
                end
            end
        endcase
        for (int i = 0; i < NUM_LEDS && i < 3; i++) begin
            s.levels[i] = lamp[i];
            s.drives[i] = drive[i];
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        // keep the log short on a badly broken run
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    task automatic queue_request(t_func f, int led, int act, int on_t, int off_t,
                                 bit rep, bit kill);
        t_req r;
        r.func = f;
        r.led_index = led[1:0];
        r.action = t_action'(act[1:0]);
        r.on_t = on_t[15:0];
        r.off_t = off_t[15:0];
        r.rep = rep;
        r.kill = kill;
        pending_reqs.push_back(r);
    endtask

    function automatic int pick_duration();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(0, 6);
        else if (roll < 95)
            return $urandom_range(0, 40);
        return $urandom_range(0, 65535);
    endfunction

    wire calm = pending_reqs.size() < CALM_TAIL;

    // Cycle counter, idle density and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 128 == 0) begin
            case ($urandom_range(0, 3))
                0:       idle_pct <= 0;
                1:       idle_pct <= 10;
                2:       idle_pct <= 25;
                default: idle_pct <= 40;
            endcase
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Request driver
    always @(posedge i_clk) begin : drive_requests
        t_req r;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                r.func = t_func'(req_bus.func);
                r.led_index = req_bus.led_index;
                r.action = t_action'(req_bus.action_kind);
                r.on_t = req_bus.on_ticks;
                r.off_t = req_bus.off_ticks;
                r.rep = req_bus.repeat_blink;
                r.kill = req_bus.lights_off;
                case (r.func)
                    FN_TICK:     n_tick++;
                    FN_ACTION:   n_action++;
                    FN_BLINK:    n_blink++;
                    default:     n_shutdown++;
                endcase
                if ((r.func == FN_ACTION || r.func == FN_BLINK) && r.led_index >= NUM_LEDS)
                    n_rejected++;
                expected_status.push_back(apply_request(r));
            end
            if (req_bus.valid && !req_bus.ready) begin
                // hold the request until taken
            end else if (req_gap > 0) begin
                req_gap--;
                req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !calm
                         && $urandom_range(0, 99) < idle_pct) begin
                req_gap = $urandom_range(0, 2);
                req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                req_bus.func <= r.func;
                req_bus.led_index <= r.led_index;
                req_bus.action_kind <= r.action;
                req_bus.on_ticks <= r.on_t;
                req_bus.off_ticks <= r.off_t;
                req_bus.repeat_blink <= r.rep;
                req_bus.lights_off <= r.kill;
                req_bus.valid <= 1'b1;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : watch_results
        t_status want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                results_seen++;
                if (expected_status.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_status.pop_front();
                    if (rsp_bus.led_levels !== want.levels)
                        report_mismatch("led_levels", rsp_bus.led_levels, want.levels);
                    if (rsp_bus.drive_enables !== want.drives)
                        report_mismatch("drive_enables", rsp_bus.drive_enables, want.drives);
                    if (rsp_bus.accepted !== want.ok)
                        report_mismatch("accepted", rsp_bus.accepted, want.ok);
                end
            end
            if (rsp_gap > 0) begin
                rsp_gap--;
                rsp_bus.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                rsp_gap = $urandom_range(0, 2);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial begin
        int roll;
        int led;
        bit tail_kill;
        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.func = FN_TICK;
        req_bus.led_index = '0;
        req_bus.action_kind = ACT_ON;
        req_bus.on_ticks = '0;
        req_bus.off_ticks = '0;
        req_bus.repeat_blink = 1'b0;
        req_bus.lights_off = 1'b0;
        rsp_bus.ready = 1'b0;
        clear_leds();

        // Directed: extremes, every function, rejects, zero durations
        queue_request(FN_BLINK,    0, 0, 65535, 0,     1, 0);
        queue_request(FN_ACTION,   1, ACT_ON, 0, 0,    0, 0);
        queue_request(FN_ACTION,   1, ACT_OFF, 0, 0,   0, 0);
        queue_request(FN_ACTION,   2, ACT_TOGGLE, 0, 0, 0, 0);
        queue_request(FN_ACTION,   2, ACT_TOGGLE, 0, 0, 0, 0);
        queue_request(FN_ACTION,   0, ACT_KEEP, 0, 0,  0, 0);
        queue_request(FN_ACTION,   3, ACT_ON, 0, 0,    0, 0);
        queue_request(FN_BLINK,    3, 0, 5, 5,         1, 0);
        queue_request(FN_BLINK,    1, 0, 0, 0,         1, 0);
        queue_request(FN_TICK,     3, 3, 65535, 65535, 1, 1);
        queue_request(FN_TICK,     0, 0, 0, 0,         0, 0);
        queue_request(FN_TICK,     0, 0, 0, 0,         0, 0);
        queue_request(FN_BLINK,    2, 0, 2, 1,         0, 0);
        queue_request(FN_TICK,     1, 0, 0, 0,         0, 0);
        queue_request(FN_TICK,     2, 0, 0, 0,         0, 0);
        queue_request(FN_TICK,     0, 0, 0, 0,         0, 0);
        queue_request(FN_BLINK,    0, 0, 1, 65535,     1, 0);
        queue_request(FN_TICK,     0, 0, 0, 0,         0, 0);
        queue_request(FN_TICK,     0, 0, 0, 0,         0, 0);
        queue_request(FN_BLINK,    1, 0, 16'hAAAA, 16'h5555, 0, 0);
        queue_request(FN_BLINK,    2, 0, 16'h5555, 16'hAAAA, 1, 0);
        queue_request(FN_SHUTDOWN, 3, 2, 0, 0,         1, 0);
        queue_request(FN_TICK,     0, 0, 0, 0,         0, 0);

        // Random: mostly ticks, then blinks and actions; kill only near the end
        for (int k = 0; k < RANDOM_REQS; k++) begin
            tail_kill = (k >= RANDOM_REQS - 40);
            roll = $urandom_range(0, 99);
            led = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
            if (roll < 50)
                queue_request(FN_TICK, $urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 1), $urandom_range(0, 1));
            else if (roll < 76)
                queue_request(FN_BLINK, led, $urandom_range(0, 3), pick_duration(),
                              pick_duration(), $urandom_range(0, 3) != 0,
                              $urandom_range(0, 1));
            else if (roll < 97)
                queue_request(FN_ACTION, led, $urandom_range(0, 3),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 1), $urandom_range(0, 1));
            else
                queue_request(FN_SHUTDOWN, $urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 1), tail_kill && $urandom_range(0, 1));
            if (k == RANDOM_REQS - 30)
                queue_request(FN_SHUTDOWN, 0, 0, 0, 0, 0, 1);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_bus.valid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (expected_status.size() != 0)
            report_mismatch("results missing", 0, expected_status.size());

        $display("covered %0d ticks, %0d actions, %0d blinks, %0d shutdowns",
                 n_tick, n_action, n_blink, n_shutdown);
        $display("%0d requests rejected for a bad LED, %0d results checked, %0d errors",
                 n_rejected, results_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
